FILE: src/voxel_column_hidden_fill_core_assert.svh
// Assertion macros for the voxel column fill core.
// Each macro takes a label, the clock, the active-low reset, a condition
// and the property that must follow from it.
`ifndef VOXEL_COLUMN_HIDDEN_FILL_CORE_ASSERT_SVH
`define VOXEL_COLUMN_HIDDEN_FILL_CORE_ASSERT_SVH

// Check in the same cycle.
`define VCHF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vchf same-cycle check failed");

// Check in the next cycle.
`define VCHF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vchf next-cycle check failed");

`endif

FILE: src/vchf_pkg.sv
package vchf_pkg;

    localparam int COLOR_W   = 32;
    localparam int ALPHA_LSB = 24;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_READ,
        ST_EMIT
    } vchf_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic read;
        logic advance;
    } vchf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic closing;
        logic last;
    } vchf_status_t;

endpackage

FILE: src/vchf_voxel_if.sv
interface vchf_voxel_if import vchf_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] voxel_color;
    logic               on_surface;
    logic               column_end;

    modport source (output valid, output voxel_color, output on_surface,
                    output column_end, input ready);
    modport sink   (input valid, input voxel_color, input on_surface,
                    input column_end, output ready);
endinterface

FILE: src/vchf_fill_if.sv
interface vchf_fill_if import vchf_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] filled_color;
    logic               write_back;
    logic               final_voxel;

    modport source (output valid, output filled_color, output write_back,
                    output final_voxel, input ready);
    modport sink   (input valid, input filled_color, input write_back,
                    input final_voxel, output ready);
endinterface

FILE: src/vchf_ram.sv
module vchf_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/vchf_ctrl.sv
module vchf_ctrl import vchf_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  vchf_status_t status,
    output vchf_cmd_t    cmd
);

    vchf_state_t state_reg;
    vchf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.load    = 1'b0;
        cmd.read    = 1'b0;
        cmd.advance = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.closing)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.advance = 1'b1;
                    state_next  = status.last ? ST_LOAD : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

FILE: src/vchf_datapath.sv
module vchf_datapath import vchf_pkg::*; #(
    parameter int COLUMN_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vchf_cmd_t          cmd,
    output vchf_status_t       status,
    input  logic [COLOR_W-1:0] voxel_color,
    input  logic               on_surface,
    input  logic               column_end,
    output logic [COLOR_W-1:0] filled_color,
    output logic               write_back,
    output logic               final_voxel
);

    localparam int CNT_W  = $clog2(COLUMN_DEPTH + 1);
    localparam int IDX_W  = (COLUMN_DEPTH > 1) ? $clog2(COLUMN_DEPTH) : 1;
    localparam int SDEPTH = (COLUMN_DEPTH + 1) / 2;
    localparam int SIDX_W = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int COL_W  = COLOR_W + 1;
    // stretch record: has_up, has_lo, upper color, lower color, length
    localparam int DESC_W = 2 + 2 * COLOR_W + CNT_W;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [SIDX_W-1:0]  sp_reg, sp_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic               run_reg, run_next;
    logic               prev_solid_reg, prev_solid_next;
    logic [CNT_W-1:0]   run_len_reg, run_len_next;
    logic               run_up_reg, run_up_next;
    logic [COLOR_W-1:0] up_color_reg, up_color_next;
    logic [COLOR_W-1:0] prev_color_reg, prev_color_next;

    logic               in_solid;
    logic               in_hidden;
    logic [CNT_W-1:0]   new_len;
    logic               new_up;
    logic [COLOR_W-1:0] new_up_color;

    logic               desc_we;
    logic [DESC_W-1:0]  desc_wdata;
    logic [DESC_W-1:0]  desc_q;
    logic [COL_W-1:0]   col_q;

    logic [COLOR_W-1:0] q_color;
    logic               q_hidden;
    logic [CNT_W-1:0]   d_len;
    logic [COLOR_W-1:0] d_lo_color;
    logic [COLOR_W-1:0] d_up_color;
    logic               d_has_lo;
    logic               d_has_up;
    logic [CNT_W:0]     upper_n;
    logic               use_up;

    vchf_ram #(
        .WIDTH (COL_W),
        .DEPTH (COLUMN_DEPTH)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (cmd.load),
        .wr_addr (cnt_reg[IDX_W-1:0]),
        .wr_data ({on_surface & in_solid, voxel_color}),
        .rd_en   (cmd.read),
        .rd_addr (cnt_reg[IDX_W-1:0]),
        .rd_data (col_q)
    );

    vchf_ram #(
        .WIDTH (DESC_W),
        .DEPTH (SDEPTH)
    ) u_desc_ram (
        .clk     (clk),
        .wr_en   (desc_we),
        .wr_addr (sp_reg),
        .wr_data (desc_wdata),
        .rd_en   (cmd.read),
        .rd_addr (sp_reg),
        .rd_data (desc_q)
    );

    // load side
    assign in_solid       = |voxel_color[COLOR_W-1:ALPHA_LSB];
    assign in_hidden      = in_solid & ~on_surface;
    assign status.closing = column_end | (cnt_reg == CNT_W'(COLUMN_DEPTH - 1));

    assign new_len      = run_reg ? CNT_W'(run_len_reg + 1'b1) : CNT_W'(1);
    assign new_up       = run_reg ? run_up_reg : prev_solid_reg;
    assign new_up_color = run_reg ? up_color_reg : prev_color_reg;

    // emit side
    assign q_color    = col_q[COLOR_W-1:0];
    assign q_hidden   = (|q_color[COLOR_W-1:ALPHA_LSB]) & ~col_q[COLOR_W];
    assign d_len      = desc_q[CNT_W-1:0];
    assign d_lo_color = desc_q[CNT_W +: COLOR_W];
    assign d_up_color = desc_q[CNT_W + COLOR_W +: COLOR_W];
    assign d_has_lo   = desc_q[DESC_W-2];
    assign d_has_up   = desc_q[DESC_W-1];
    assign upper_n    = ({1'b0, d_len} + 1'b1) >> 1;
    assign use_up     = {1'b0, k_reg} < upper_n;

    assign status.last = (cnt_reg + CNT_W'(1)) == n_reg;
    assign final_voxel = status.last;
    assign write_back  = q_hidden;

    always_comb
    begin
        filled_color = q_color;
        if (q_hidden)
        begin
            if (d_has_up && d_has_lo)
            begin
                filled_color = use_up ? d_up_color : d_lo_color;
            end
            else if (d_has_up)
            begin
                filled_color = d_up_color;
            end
            else if (d_has_lo)
            begin
                filled_color = d_lo_color;
            end
        end
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        sp_next         = sp_reg;
        k_next          = k_reg;
        run_next        = run_reg;
        prev_solid_next = prev_solid_reg;
        run_len_next    = run_len_reg;
        run_up_next     = run_up_reg;
        up_color_next   = up_color_reg;
        prev_color_next = prev_color_reg;
        desc_we         = 1'b0;
        desc_wdata      = {run_up_reg, in_solid, up_color_reg, voxel_color, run_len_reg};

        if (cmd.load)
        begin
            prev_color_next = voxel_color;
            prev_solid_next = in_solid & ~status.closing;
            if (in_hidden)
            begin
                // extend or open the stretch; close it only at column end
                run_next      = ~status.closing;
                run_len_next  = new_len;
                run_up_next   = new_up;
                up_color_next = new_up_color;
                if (status.closing)
                begin
                    desc_we    = 1'b1;
                    desc_wdata = {new_up, 1'b0, new_up_color, {COLOR_W{1'b0}}, new_len};
                end
            end
            else if (run_reg)
            begin
                // stretch ends on this voxel
                desc_we  = 1'b1;
                run_next = 1'b0;
                sp_next  = SIDX_W'(sp_reg + 1'b1);
            end

            if (status.closing)
            begin
                n_next   = CNT_W'(cnt_reg + 1'b1);
                cnt_next = '0;
                sp_next  = '0;
                k_next   = '0;
                run_next = 1'b0;
            end
            else
            begin
                cnt_next = CNT_W'(cnt_reg + 1'b1);
            end
        end

        if (cmd.advance)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            if (q_hidden)
            begin
                if ((k_reg + CNT_W'(1)) == d_len)
                begin
                    k_next  = '0;
                    sp_next = SIDX_W'(sp_reg + 1'b1);
                end
                else
                begin
                    k_next = CNT_W'(k_reg + 1'b1);
                end
            end
            if (status.last)
            begin
                cnt_next = '0;
                sp_next  = '0;
                k_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            n_reg          <= '0;
            sp_reg         <= '0;
            k_reg          <= '0;
            run_reg        <= 1'b0;
            prev_solid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            n_reg          <= n_next;
            sp_reg         <= sp_next;
            k_reg          <= k_next;
            run_reg        <= run_next;
            prev_solid_reg <= prev_solid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_len_reg    <= run_len_next;
        run_up_reg     <= run_up_next;
        up_color_reg   <= up_color_next;
        prev_color_reg <= prev_color_next;
    end

endmodule

FILE: src/voxel_column_hidden_fill_core.sv
// Order: the closing voxel of a column is taken first; then each result
//   is read from the column buffer and presented, and the next read waits
//   until the sink has taken the result.
// A new column is taken only once the last result of the column is out.
// Reset: rst_n clears the controller and all counters at once; the column
//   and stretch buffers are not cleared, no clearing pass is needed.
`include "voxel_column_hidden_fill_core_assert.svh"

module voxel_column_hidden_fill_core import vchf_pkg::*; #(
    parameter int COLUMN_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    vchf_voxel_if.sink        vox,
    vchf_fill_if.source       fill
);

    // The column is loaded one voxel per word into the column buffer.
    // While it loads, the datapath tracks the current hidden stretch and,
    // when the stretch ends, stores one record: whether a solid voxel sits
    // above and below it, those two colors and the stretch length.
    // At emit time the column is read back in input order; each hidden
    // voxel looks up its stretch record and picks the upper color for the
    // first ceil(len/2) voxels and the lower color for the rest.

    vchf_cmd_t    cmd;
    vchf_status_t status;

    // Sequencer: load, then alternate buffer read and result presentation.
    vchf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vox.valid),
        .in_ready  (vox.ready),
        .out_valid (fill.valid),
        .out_ready (fill.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Buffers, stretch tracking and the color selection.
    vchf_datapath #(
        .COLUMN_DEPTH (COLUMN_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .voxel_color  (vox.voxel_color),
        .on_surface   (vox.on_surface),
        .column_end   (vox.column_end),
        .filled_color (fill.filled_color),
        .write_back   (fill.write_back),
        .final_voxel  (fill.final_voxel)
    );

    // Loading and emitting never overlap.
    `VCHF_ASSERT_SAME(a_no_overlap, clk, rst_n, vox.ready, !fill.valid)
    // A closing word stops input until the column has been emitted.
    `VCHF_ASSERT_NEXT(a_close_stops_input, clk, rst_n, vox.valid && vox.ready && status.closing, !vox.ready)
    // After the last result goes out, input opens again.
    `VCHF_ASSERT_NEXT(a_final_reopens, clk, rst_n, fill.valid && fill.ready && fill.final_voxel, vox.ready)
    // A rewritten voxel always takes a solid color.
    `VCHF_ASSERT_SAME(a_fill_solid, clk, rst_n, fill.valid && fill.write_back, fill.filled_color[31:24] != 8'd0)

endmodule

FILE: tb/sv/voxel_column_hidden_fill_core_test.sv
module voxel_column_hidden_fill_core_test import vchf_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Column depth of the block under test and the limits of the run.
    localparam int     VOXELS_PER_COLUMN = 64;
    localparam int     ALPHA_W           = COLOR_W - ALPHA_LSB;
    localparam longint CYCLE_LIMIT       = 400000;
    localparam int     HOLD_OFF_CYCLES   = 400;
    localparam int     SETTLE_CYCLES     = 20;
    localparam int     MAX_REPORTS       = 10;

    // Kinds of voxel the random columns are built from.
    typedef enum int {
        VK_EMPTY,
        VK_SURFACE,
        VK_HIDDEN
    } voxel_kind_t;

    // One word on the voxel channel.
    typedef struct {
        logic [COLOR_W-1:0] color;
        logic               surface;
        logic               last;
    } voxel_word_t;

    // One word on the fill channel.
    typedef struct {
        logic [COLOR_W-1:0] color;
        logic               write_back;
        logic               final_voxel;
    } fill_word_t;

    logic clk;
    logic rst_n;

    vchf_voxel_if vox_bus ();
    vchf_fill_if  fill_bus ();

    voxel_column_hidden_fill_core #(
        .COLUMN_DEPTH (VOXELS_PER_COLUMN)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .vox   (vox_bus.sink),
        .fill  (fill_bus.source)
    );

    // Column being collected by the predictor: colors and effective surface bits.
    logic [COLOR_W-1:0] column_rgba    [VOXELS_PER_COLUMN];
    logic               column_exposed [VOXELS_PER_COLUMN];
    int                 column_fill = 0;

    // Voxel words waiting to go out, and fill words the block still owes.
    voxel_word_t voxels_to_send [$];
    fill_word_t  fill_words_due [$];

    bit     voxel_taken    = 1'b0;
    bit     sender_idles   = 1'b1;
    bit     receiver_idles = 1'b1;
    int     send_gap       = 0;
    int     sink_gap       = 0;
    int     hold_left      = 0;
    int     stall_asks     = 0;
    int     stall_served   = 0;
    int     queued_count   = 0;
    int     fault_count    = 0;
    longint cycle_count    = 0;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Column fill predictor
    // ------------------------------------------------------------------

    // A voxel is solid when its alpha byte is nonzero.
    function automatic logic is_opaque(logic [COLOR_W-1:0] c);
        return c[COLOR_W-1:ALPHA_LSB] != '0;
    endfunction

    // Hidden: solid but not on the surface.
    function automatic logic is_buried(int i);
        return is_opaque(column_rgba[i]) && !column_exposed[i];
    endfunction

    // Close the collected column: paint every hidden stretch from the
    // surface voxels that bound it, then queue one fill word per voxel.
    task automatic paint_column();
        logic [COLOR_W-1:0] painted [VOXELS_PER_COLUMN];
        logic               has_up;
        logic               has_lo;
        int                 top;
        int                 bot;
        int                 len;
        int                 upper;
        int                 i;
        int                 k;
        fill_word_t         w;

        for (i = 0; i < column_fill; i++)
            painted[i] = column_rgba[i];

        i = 0;
        while (i < column_fill)
        begin
            if (!is_buried(i))
            begin
                i++;
            end
            else
            begin
                // Find the maximal hidden stretch starting here.
                top = i;
                while (i < column_fill && is_buried(i))
                    i++;
                bot = i - 1;
                // A solid neighbor outside the stretch is a surface voxel;
                // the column top and bottom lend no color.
                has_up = (top > 0) && is_opaque(column_rgba[top - 1]);
                has_lo = (bot + 1 < column_fill) && is_opaque(column_rgba[bot + 1]);
                len    = bot - top + 1;
                // Upper half rounds up.
                upper  = (len + 1) / 2;
                for (k = 0; k < len; k++)
                begin
                    if (has_up && has_lo)
                        painted[top + k] = (k < upper) ? column_rgba[top - 1]
                                                       : column_rgba[bot + 1];
                    else if (has_up)
                        painted[top + k] = column_rgba[top - 1];
                    else if (has_lo)
                        painted[top + k] = column_rgba[bot + 1];
                end
            end
        end

        for (i = 0; i < column_fill; i++)
        begin
            w.color       = painted[i];
            w.write_back  = is_buried(i);
            w.final_voxel = (i == column_fill - 1);
            fill_words_due.push_back(w);
        end
        column_fill = 0;
    endtask

    // Take one accepted voxel; close the column on its end flag or when
    // the buffer is full.
    task automatic absorb_voxel(voxel_word_t w);
        column_rgba[column_fill]    = w.color;
        // An empty voxel is never a surface, whatever its flag says.
        column_exposed[column_fill] = w.surface && is_opaque(w.color);
        column_fill++;
        if (w.last || column_fill == VOXELS_PER_COLUMN)
            paint_column();
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic voxel_word_t make_voxel(voxel_kind_t kind, logic last);
        voxel_word_t w;
        w.color   = $urandom;
        w.last    = last;
        w.surface = 1'b0;
        case (kind)
            VK_EMPTY:
            begin
                // Empty voxel; a stray surface flag must be ignored.
                w.color[COLOR_W-1:ALPHA_LSB] = '0;
                w.surface = 1'($urandom_range(0, 1));
            end
            VK_SURFACE:
            begin
                if (!is_opaque(w.color))
                    w.color[COLOR_W-1:ALPHA_LSB] =
                        ALPHA_W'($urandom_range(1, 2**ALPHA_W - 1));
                w.surface = 1'b1;
            end
            default:
            begin
                if (!is_opaque(w.color))
                    w.color[COLOR_W-1:ALPHA_LSB] =
                        ALPHA_W'($urandom_range(1, 2**ALPHA_W - 1));
                w.surface = 1'b0;
            end
        endcase
        return w;
    endfunction

    task automatic offer_voxel(logic [COLOR_W-1:0] color, logic surface, logic last);
        voxel_word_t w;
        w.color   = color;
        w.surface = surface;
        w.last    = last;
        voxels_to_send.push_back(w);
        queued_count++;
    endtask

    // Queue a column of random voxels; an unclosed column relies on the
    // buffer filling up to close it.
    task automatic queue_column(int len, logic closed);
        voxel_kind_t kind;
        int          r;
        int          j;
        for (j = 0; j < len; j++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                kind = VK_HIDDEN;
            else if (r < 75)
                kind = VK_SURFACE;
            else
                kind = VK_EMPTY;
            voxels_to_send.push_back(make_voxel(kind, closed && (j == len - 1)));
            queued_count++;
        end
    endtask

    // Mostly short columns, some long ones, a few that run to full depth.
    task automatic queue_random_columns(int words);
        int goal;
        int r;
        goal = queued_count + words;
        while (queued_count < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                queue_column($urandom_range(1, 12), 1'b1);
            else if (r < 93)
                queue_column($urandom_range(13, VOXELS_PER_COLUMN - 1), 1'b1);
            else
                queue_column(VOXELS_PER_COLUMN, 1'($urandom_range(0, 1)));
        end
    endtask

    // Hold until every voxel is sent and every fill word has come back.
    task automatic await_drain();
        while (voxels_to_send.size() != 0 || vox_bus.valid || fill_words_due.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Voxel driver: change inputs on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_voxels
        voxel_word_t w;
        if (!rst_n)
        begin
            vox_bus.valid <= 1'b0;
        end
        else if (!vox_bus.valid || voxel_taken)
        begin
            // Slot is free: idle for the gap, else advance to the next word.
            voxel_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                vox_bus.valid <= 1'b0;
            end
            else if (voxels_to_send.size() > 0)
            begin
                w = voxels_to_send.pop_front();
                vox_bus.valid       <= 1'b1;
                vox_bus.voxel_color <= w.color;
                vox_bus.on_surface  <= w.surface;
                vox_bus.column_end  <= w.last;
                send_gap = sender_idles ? pick_gap() : 0;
            end
            else
            begin
                vox_bus.valid <= 1'b0;
            end
        end
    end

    // Feed each accepted voxel to the predictor.
    always @(posedge clk)
    begin : take_voxels
        voxel_word_t w;
        if (rst_n && vox_bus.valid && vox_bus.ready)
        begin
            w.color   = vox_bus.voxel_color;
            w.surface = vox_bus.on_surface;
            w.last    = vox_bus.column_end;
            absorb_voxel(w);
            voxel_taken = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Fill sink: ready changes on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_ready
        if (!rst_n)
        begin
            fill_bus.ready <= 1'b0;
        end
        else if (stall_asks != stall_served)
        begin
            // Start a long hold-off so the block backs up into its input.
            stall_served++;
            hold_left = HOLD_OFF_CYCLES;
            fill_bus.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            fill_bus.ready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            fill_bus.ready <= 1'b0;
        end
        else
        begin
            fill_bus.ready <= 1'b1;
            sink_gap = receiver_idles ? pick_gap() : 0;
        end
    end

    // ------------------------------------------------------------------
    // Fill monitor: compare each accepted word with the oldest one owed
    // ------------------------------------------------------------------
    task automatic note_fault(string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : check_fill
        fill_word_t got;
        fill_word_t want;
        if (rst_n && fill_bus.valid && fill_bus.ready)
        begin
            got.color       = fill_bus.filled_color;
            got.write_back  = fill_bus.write_back;
            got.final_voxel = fill_bus.final_voxel;
            if (fill_words_due.size() == 0)
            begin
                note_fault($sformatf("unexpected fill word: color %h write_back %b final %b",
                                     got.color, got.write_back, got.final_voxel));
            end
            else
            begin
                want = fill_words_due.pop_front();
                if (got.color !== want.color || got.write_back !== want.write_back
                    || got.final_voxel !== want.final_voxel)
                    note_fault($sformatf({"fill word mismatch: expected color %h write_back %b ",
                                          "final %b, got color %h write_back %b final %b"},
                                         want.color, want.write_back, want.final_voxel,
                                         got.color, got.write_back, got.final_voxel));
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : run_phases
        vox_bus.valid       = 1'b0;
        vox_bus.voxel_color = '0;
        vox_bus.on_surface  = 1'b0;
        vox_bus.column_end  = 1'b0;
        fill_bus.ready      = 1'b0;
        rst_n               = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed columns.
        // Single voxel, every bit set.
        offer_voxel(32'hFFFF_FFFF, 1'b1, 1'b1);
        // Single empty voxel carrying a stray surface flag.
        offer_voxel(32'h0000_0000, 1'b1, 1'b1);
        // Hidden top stretch bounded only below, even stretch between two
        // surfaces, hidden bottom voxel bounded only above.
        offer_voxel(32'h01AA_BBCC, 1'b0, 1'b0);
        offer_voxel(32'hFE00_0000, 1'b0, 1'b0);
        offer_voxel(32'h8011_2233, 1'b1, 1'b0);
        offer_voxel(32'h0F12_3456, 1'b0, 1'b0);
        offer_voxel(32'h2265_4321, 1'b0, 1'b0);
        offer_voxel(32'h33DE_AD00, 1'b0, 1'b0);
        offer_voxel(32'h44BE_EF11, 1'b0, 1'b0);
        offer_voxel(32'h7F44_5566, 1'b1, 1'b0);
        offer_voxel(32'h11FF_FFFF, 1'b0, 1'b1);
        // No surface anywhere: colors stay as they are.
        offer_voxel(32'h3300_0001, 1'b0, 1'b0);
        offer_voxel(32'h5500_0002, 1'b0, 1'b0);
        offer_voxel(32'h7700_0004, 1'b0, 1'b1);
        // Odd stretch between surfaces, then an empty voxel that breaks the
        // solid run so the next stretch sees only the surface below it.
        offer_voxel(32'hFF00_00FF, 1'b1, 1'b0);
        offer_voxel(32'h0AAA_AAAA, 1'b0, 1'b0);
        offer_voxel(32'h0B55_5555, 1'b0, 1'b0);
        offer_voxel(32'h0CCC_CCCC, 1'b0, 1'b0);
        offer_voxel(32'hFF00_FF00, 1'b1, 1'b0);
        offer_voxel(32'h00FF_FFFF, 1'b1, 1'b0);
        offer_voxel(32'h20AB_CDEF, 1'b0, 1'b0);
        offer_voxel(32'h40FE_DCBA, 1'b1, 1'b1);
        await_drain();

        // Back-pressure: hold the sink off while a full-depth column and a
        // few more are offered, so the block fills and stalls its input.
        stall_asks++;
        queue_column(VOXELS_PER_COLUMN, 1'b0);
        queue_column(5, 1'b1);
        queue_column(9, 1'b1);
        await_drain();

        // Stretch with no idling on either side.
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        queue_random_columns(100);
        await_drain();

        // Bulk random traffic with idling on both sides.
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        queue_random_columns(200);
        await_drain();

        // Let any stray word show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0 && fill_words_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
